### hw/rtl/obb2d_pkg.sv
package obb2d_pkg;

  // Field widths
  localparam int unsigned CenterW = 32;  // signed Q16.16 center coordinate
  localparam int unsigned TrigW   = 16;  // signed Q1.14 cosine / sine
  localparam int unsigned ExtW    = 31;  // unsigned Q15.16 full size

  // Datapath widths
  localparam int unsigned DiffW   = CenterW + 1;       // center difference
  localparam int unsigned AxisW   = TrigW + 1;         // axis component, holds -(-2^15)
  localparam int unsigned DistPW  = DiffW + AxisW;     // d.x * v.x
  localparam int unsigned DistSW  = DistPW + 1;        // d.x*v.x + d.y*v.y
  localparam int unsigned Dist2W  = DistSW + 1;        // 2 * |distance|
  localparam int unsigned ProjPW  = 2 * AxisW;         // u.x * v.x
  localparam int unsigned ProjSW  = ProjPW + 1;        // u.x*v.x + u.y*v.y
  localparam int unsigned ProjFrac = 14;               // Q.28 -> Q.14
  localparam int unsigned ProjQW  = ProjSW + 1 - ProjFrac;  // rounded magnitude
  localparam int unsigned TermW   = ExtW + ProjQW;     // size * projection
  localparam int unsigned SumW    = TermW + 2;         // sum of four terms

  localparam int unsigned RoundBias = 8192;            // half an LSB of Q.14

  localparam int unsigned NumAxes   = 4;
  localparam int unsigned PipeDepth = 6;

  // Axis index codes
  localparam int unsigned AxisAUp    = 0;
  localparam int unsigned AxisARight = 1;
  localparam int unsigned AxisBUp    = 2;
  localparam int unsigned AxisBRight = 3;

  typedef struct packed {
    logic signed [AxisW-1:0] x;
    logic signed [AxisW-1:0] y;
  } axis_t;

endpackage

### hw/rtl/obb2d_overlap_test.sv
// Throughput: one request per cycle, sustained; busy never rises.
// Reset clears the valid pipeline only; data registers carry no reset.
// The receiver cannot stall: valid_o is a one-cycle strobe with overlap_o.
module obb2d_overlap_test (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [obb2d_pkg::CenterW-1:0] a_center_x_i,
  input  logic signed [obb2d_pkg::CenterW-1:0] a_center_y_i,
  input  logic signed [obb2d_pkg::TrigW-1:0]   a_cos_i,
  input  logic signed [obb2d_pkg::TrigW-1:0]   a_sin_i,
  input  logic [obb2d_pkg::ExtW-1:0]           a_width_i,
  input  logic [obb2d_pkg::ExtW-1:0]           a_height_i,
  input  logic signed [obb2d_pkg::CenterW-1:0] b_center_x_i,
  input  logic signed [obb2d_pkg::CenterW-1:0] b_center_y_i,
  input  logic signed [obb2d_pkg::TrigW-1:0]   b_cos_i,
  input  logic signed [obb2d_pkg::TrigW-1:0]   b_sin_i,
  input  logic [obb2d_pkg::ExtW-1:0]           b_width_i,
  input  logic [obb2d_pkg::ExtW-1:0]           b_height_i,
  output logic                                 valid_o,
  output logic                                 overlap_o
);

  // Pipeline, one request per cycle, six register stages:
  //   1 center difference, axis vectors (right = (cos, sin), up = (-sin, cos))
  //   2 products onto each candidate axis (distance and four box axes)
  //   3 magnitudes; box projections rounded to Q.14
  //   4 size times rounded projection
  //   5 sum of the four extent terms
  //   6 strict compare 2*distance > extent sum, per axis
  // The rate is set by the widest multiplier stage, which is fully pipelined,
  // so nothing ever holds a request back.

  localparam int unsigned N = obb2d_pkg::NumAxes;

  logic [obb2d_pkg::PipeDepth-1:0] vld_d, vld_q;

  logic signed [obb2d_pkg::DiffW-1:0] dx_d, dx_q, dy_d, dy_q;
  obb2d_pkg::axis_t [N-1:0]           axes_d, axes_q;
  logic [N-1:0][obb2d_pkg::ExtW-1:0]  ext_d, ext_q;
  logic [N-1:0]                       sep;

  assign busy = 1'b0;

  // stage 1: differences and axes; widen by one bit so -(-2^15) fits
  always_comb begin
    dx_d = {a_center_x_i[obb2d_pkg::CenterW-1], a_center_x_i}
         - {b_center_x_i[obb2d_pkg::CenterW-1], b_center_x_i};
    dy_d = {a_center_y_i[obb2d_pkg::CenterW-1], a_center_y_i}
         - {b_center_y_i[obb2d_pkg::CenterW-1], b_center_y_i};

    axes_d[obb2d_pkg::AxisAUp].x    = -{a_sin_i[obb2d_pkg::TrigW-1], a_sin_i};
    axes_d[obb2d_pkg::AxisAUp].y    =  {a_cos_i[obb2d_pkg::TrigW-1], a_cos_i};
    axes_d[obb2d_pkg::AxisARight].x =  {a_cos_i[obb2d_pkg::TrigW-1], a_cos_i};
    axes_d[obb2d_pkg::AxisARight].y =  {a_sin_i[obb2d_pkg::TrigW-1], a_sin_i};
    axes_d[obb2d_pkg::AxisBUp].x    = -{b_sin_i[obb2d_pkg::TrigW-1], b_sin_i};
    axes_d[obb2d_pkg::AxisBUp].y    =  {b_cos_i[obb2d_pkg::TrigW-1], b_cos_i};
    axes_d[obb2d_pkg::AxisBRight].x =  {b_cos_i[obb2d_pkg::TrigW-1], b_cos_i};
    axes_d[obb2d_pkg::AxisBRight].y =  {b_sin_i[obb2d_pkg::TrigW-1], b_sin_i};

    // each box uses its own size: height goes with up, width with right
    ext_d[obb2d_pkg::AxisAUp]    = a_height_i;
    ext_d[obb2d_pkg::AxisARight] = a_width_i;
    ext_d[obb2d_pkg::AxisBUp]    = b_height_i;
    ext_d[obb2d_pkg::AxisBRight] = b_width_i;

    // advance the valid bit with the data; every request is taken
    vld_d = {vld_q[obb2d_pkg::PipeDepth-2:0], start & ~busy};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload registers: no reset, overwritten every cycle
  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    axes_q <= axes_d;
    ext_q  <= ext_d;
  end

  // one lane per candidate axis
  for (genvar k = 0; k < N; k++) begin : g_lane
    obb2d_axis_lane u_lane (
      .clk_i  (clk_i),
      .dx_i   (dx_q),
      .dy_i   (dy_q),
      .v_i    (axes_q[k]),
      .axes_i (axes_q),
      .ext_i  (ext_q),
      .sep_o  (sep[k])
    );
  end

  // overlap when no axis separates the boxes
  assign valid_o   = vld_q[obb2d_pkg::PipeDepth-1];
  assign overlap_o = ~(|sep);

  a_req_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##6 valid_o)
    else $error("request did not produce a result after six cycles");

  a_result_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, 6))
    else $error("result strobe without a matching request");

  a_same_center_overlaps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && (a_center_x_i == b_center_x_i) && (a_center_y_i == b_center_y_i))
      |-> ##6 (valid_o && overlap_o))
    else $error("boxes with coincident centers reported as separated");

endmodule

### hw/rtl/obb2d_axis_lane.sv
// One candidate axis: project the center distance and all four box sizes
// onto it, then compare. Five register stages, no stall.
module obb2d_axis_lane (
  input  logic                                        clk_i,
  input  logic signed [obb2d_pkg::DiffW-1:0]          dx_i,
  input  logic signed [obb2d_pkg::DiffW-1:0]          dy_i,
  input  obb2d_pkg::axis_t                            v_i,
  input  obb2d_pkg::axis_t [obb2d_pkg::NumAxes-1:0]   axes_i,
  input  logic [obb2d_pkg::NumAxes-1:0][obb2d_pkg::ExtW-1:0] ext_i,
  output logic                                        sep_o
);

  localparam int unsigned N = obb2d_pkg::NumAxes;

  // stage 2: products
  logic signed [obb2d_pkg::DistPW-1:0] pdx_d, pdx_q, pdy_d, pdy_q;
  logic signed [obb2d_pkg::ProjPW-1:0] ppx_d [N];
  logic signed [obb2d_pkg::ProjPW-1:0] ppx_q [N];
  logic signed [obb2d_pkg::ProjPW-1:0] ppy_d [N];
  logic signed [obb2d_pkg::ProjPW-1:0] ppy_q [N];
  logic [obb2d_pkg::ExtW-1:0] ext2_q [N];

  // stage 3: magnitudes and rounding
  logic [obb2d_pkg::DistSW-1:0] dsum;
  logic [obb2d_pkg::DistSW-1:0] dmag;
  logic [obb2d_pkg::Dist2W-1:0] dist3_d, dist3_q;
  logic [obb2d_pkg::ProjSW-1:0] psum [N];
  logic [obb2d_pkg::ProjSW-1:0] pmag [N];
  logic [obb2d_pkg::ProjSW:0]   prnd [N];
  logic [obb2d_pkg::ProjQW-1:0] q_d [N];
  logic [obb2d_pkg::ProjQW-1:0] q_q [N];
  logic [obb2d_pkg::ExtW-1:0]   ext3_q [N];

  // stage 4: extent terms
  logic [obb2d_pkg::TermW-1:0]  term_d [N];
  logic [obb2d_pkg::TermW-1:0]  term_q [N];
  logic [obb2d_pkg::Dist2W-1:0] dist4_q;

  // stage 5: extent sum
  logic [obb2d_pkg::SumW-1:0]   sum_d, sum_q;
  logic [obb2d_pkg::Dist2W-1:0] dist5_q;

  // stage 6: compare
  logic sep_d, sep_q;

  always_comb begin
    pdx_d = dx_i * $signed(v_i.x);
    pdy_d = dy_i * $signed(v_i.y);
    for (int m = 0; m < N; m++) begin
      ppx_d[m] = $signed(axes_i[m].x) * $signed(v_i.x);
      ppy_d[m] = $signed(axes_i[m].y) * $signed(v_i.y);
    end
  end

  always_comb begin
    dsum    = {pdx_q[obb2d_pkg::DistPW-1], pdx_q} + {pdy_q[obb2d_pkg::DistPW-1], pdy_q};
    dmag    = dsum[obb2d_pkg::DistSW-1] ? (~dsum + obb2d_pkg::DistSW'(1)) : dsum;
    dist3_d = {dmag, 1'b0};
    for (int m = 0; m < N; m++) begin
      psum[m] = {ppx_q[m][obb2d_pkg::ProjPW-1], ppx_q[m]}
              + {ppy_q[m][obb2d_pkg::ProjPW-1], ppy_q[m]};
      pmag[m] = psum[m][obb2d_pkg::ProjSW-1] ? (~psum[m] + obb2d_pkg::ProjSW'(1)) : psum[m];
      // round half away from zero on the magnitude
      prnd[m] = {1'b0, pmag[m]} + (obb2d_pkg::ProjSW + 1)'(obb2d_pkg::RoundBias);
      q_d[m]  = prnd[m][obb2d_pkg::ProjSW:obb2d_pkg::ProjFrac];
    end
  end

  always_comb begin
    for (int m = 0; m < N; m++) begin
      term_d[m] = obb2d_pkg::TermW'(ext3_q[m]) * obb2d_pkg::TermW'(q_q[m]);
    end
    sum_d = obb2d_pkg::SumW'(term_q[0]) + obb2d_pkg::SumW'(term_q[1])
          + obb2d_pkg::SumW'(term_q[2]) + obb2d_pkg::SumW'(term_q[3]);
    // touching counts as overlap, so the test is strict
    sep_d = obb2d_pkg::SumW'(dist5_q) > sum_q;
  end

  always_ff @(posedge clk_i) begin
    pdx_q   <= pdx_d;
    pdy_q   <= pdy_d;
    dist3_q <= dist3_d;
    dist4_q <= dist3_q;
    dist5_q <= dist4_q;
    sum_q   <= sum_d;
    sep_q   <= sep_d;
    for (int m = 0; m < N; m++) begin
      ppx_q[m]  <= ppx_d[m];
      ppy_q[m]  <= ppy_d[m];
      ext2_q[m] <= ext_i[m];
      ext3_q[m] <= ext2_q[m];
      q_q[m]    <= q_d[m];
      term_q[m] <= term_d[m];
    end
  end

  assign sep_o = sep_q;

endmodule
